@@ rtl/scms_pkg.sv @@
// shared types and constants for the minimum-energy seam finder
`default_nettype none

package scms_pkg;

  localparam int COL_W    = 8;
  localparam int LINE_W   = 8;
  localparam int ENERGY_W = 20;
  localparam int COST_W   = 32;
  localparam int DIM_W    = 9;
  localparam int ADDR_W   = LINE_W + COL_W;

  localparam logic [DIM_W-1:0] MIN_DIM       = 9'd2;
  localparam logic [DIM_W-1:0] MAX_LINE_LEN  = 9'd256;
  localparam logic [DIM_W-1:0] MAX_LINE_CNT  = 9'd256;

  localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

  // configuration register indexes
  localparam logic REG_LINE_LENGTH = 1'b0;
  localparam logic REG_LINE_COUNT  = 1'b1;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [ENERGY_W-1:0] pixel_cost;
    logic [LINE_W-1:0]   line_select;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  seam_position;
    logic [COST_W-1:0] seam_total;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/seam_carving_min_seam_top.sv @@
// minimum-energy seam finder: cost accumulation, last-line scan and backtrack
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready   | in_data (in_item_t)
//  out     | output    | out_valid/out_ready | out_data (out_item_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// a load on line 0 goes from ST_IDLE straight to ST_WRITE; one on a later line
// first passes ST_NB_C, ST_NB_L, ST_NB_R and ST_NB_E: the three neighbor costs
// come one at a time from the single read port of the cost memory; the last
// pixel of an image adds a last-line scan and backtrack before in_ready returns
// a read goes via ST_RESP; loads are still taken while a result waits on out
// reset is synchronous, active low; the memories need no clearing
`default_nettype none

module seam_carving_min_seam_top
  import scms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RESP, ST_NB_C, ST_NB_L, ST_NB_R, ST_NB_E, ST_WRITE, ST_SCAN0, ST_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  logic                phase_done_r, phase_done_nxt;
  logic [LINE_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]    ncol_r, ncol_nxt;
  logic [COST_W-1:0]   best_r, best_nxt;
  logic [COL_W-1:0]    pick_r, pick_nxt;
  logic [DIM_W-1:0]    k_r, k_nxt;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [COST_W-1:0]   best_total_r, best_total_nxt;
  logic [LINE_W-1:0]   sel_r, sel_nxt;
  logic [DIM_W-1:0]    len_r, len_nxt;
  logic [DIM_W-1:0]    cnt_r, cnt_nxt;
  logic                bt_r, bt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // memories
  logic [COST_W-1:0] cost_mem [2**ADDR_W];
  logic [COL_W-1:0]  seam_mem [2**LINE_W];
  logic [COST_W-1:0] rd_data_r;
  logic [COL_W-1:0]  seam_rd_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              cost_we;
  logic [ADDR_W-1:0] cost_wa;
  logic [COST_W-1:0] cost_wd;
  logic              seam_we;
  logic [LINE_W-1:0] seam_wa;
  logic [COL_W-1:0]  seam_wd;

  logic [DIM_W-1:0]    eff_len, eff_cnt;
  logic [LINE_W-1:0]   last_line;
  logic                in_xfer, lt;
  logic                restart;
  logic [COL_W-1:0]    ld_col;
  logic [LINE_W-1:0]   ld_line;
  logic                has_right;
  logic                col_last, line_last;
  logic [DIM_W-1:0]    k_inc;
  logic [COL_W-1:0]    k_inc_col;
  logic                take;
  logic [COST_W-1:0]   sc_best, fin_best;
  logic [COL_W-1:0]    sc_pick, fin_pick;
  logic [COST_W:0]     sum;

  always_comb begin
    if (len_r < MIN_DIM) eff_len = MIN_DIM;
    else if (len_r > MAX_LINE_LEN) eff_len = MAX_LINE_LEN;
    else eff_len = len_r;
    if (cnt_r < MIN_DIM) eff_cnt = MIN_DIM;
    else if (cnt_r > MAX_LINE_CNT) eff_cnt = MAX_LINE_CNT;
    else eff_cnt = cnt_r;
  end

  assign last_line = LINE_W'(eff_cnt - 9'd1);
  assign in_ready  = (state_r == ST_IDLE) &&
                     (!out_valid_r || out_ready || in_data.req_type == REQ_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the one comparator shared by neighbor search and last-line scan
  assign lt        = rd_data_r < best_r;
  assign has_right = ({1'b0, ncol_r} + 9'd1) < eff_len;
  assign restart   = phase_done_r || ({1'b0, col_r} >= eff_len) ||
                     ({1'b0, line_r} >= eff_cnt);
  assign ld_col    = restart ? '0 : col_r;
  assign ld_line   = restart ? '0 : line_r;
  assign col_last  = ({1'b0, col_r} + 9'd1) >= eff_len;
  assign line_last = ({1'b0, line_r} + 9'd1) >= eff_cnt;
  assign k_inc     = k_r + 9'd1;
  assign k_inc_col = k_inc[COL_W-1:0];
  assign take      = (k_r == '0) || lt;
  assign sc_best   = take ? rd_data_r : best_r;
  assign sc_pick   = take ? k_r[COL_W-1:0] : pick_r;
  assign fin_best  = (has_right && lt) ? rd_data_r : best_r;
  assign fin_pick  = (has_right && lt) ? ncol_r + 8'd1 : pick_r;
  assign sum       = {1'b0, best_r} + {{(COST_W+1-ENERGY_W){1'b0}}, energy_r};

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    phase_done_nxt = phase_done_r;
    row_nxt        = row_r;
    ncol_nxt       = ncol_r;
    best_nxt       = best_r;
    pick_nxt       = pick_r;
    k_nxt          = k_r;
    energy_nxt     = energy_r;
    best_total_nxt = best_total_r;
    sel_nxt        = sel_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    bt_nxt         = bt_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_addr        = {row_r, ncol_r};
    cost_we        = 1'b0;
    cost_wa        = {line_r, col_r};
    cost_wd        = sum[COST_W] ? COST_SAT : sum[COST_W-1:0];
    seam_we        = 1'b0;
    seam_wa        = row_r;
    seam_wd        = fin_pick;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.req_type == REQ_READ) begin
            sel_nxt   = in_data.line_select;
            state_nxt = ST_RESP;
          end else begin
            energy_nxt     = in_data.pixel_cost;
            bt_nxt         = 1'b0;
            col_nxt        = ld_col;
            line_nxt       = ld_line;
            phase_done_nxt = 1'b0;
            if (ld_line == '0) begin
              best_nxt  = '0;
              state_nxt = ST_WRITE;
            end else begin
              row_nxt   = ld_line - 8'd1;
              ncol_nxt  = ld_col;
              state_nxt = ST_NB_C;
            end
          end
        end
      end
      ST_RESP: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.line_number   = sel_r;
        out_data_nxt.seam_position = ({1'b0, sel_r} < eff_cnt) ? seam_rd_r : '0;
        out_data_nxt.seam_total    = best_total_r;
        state_nxt                  = ST_IDLE;
      end
      ST_NB_C: begin
        rd_addr   = {row_r, ncol_r};
        state_nxt = ST_NB_L;
      end
      ST_NB_L: begin
        best_nxt  = rd_data_r;
        pick_nxt  = ncol_r;
        rd_addr   = {row_r, ncol_r - 8'd1};
        state_nxt = ST_NB_R;
      end
      ST_NB_R: begin
        if (ncol_r != '0 && lt) begin
          best_nxt = rd_data_r;
          pick_nxt = ncol_r - 8'd1;
        end
        rd_addr   = {row_r, ncol_r + 8'd1};
        state_nxt = ST_NB_E;
      end
      ST_NB_E: begin
        best_nxt = fin_best;
        pick_nxt = fin_pick;
        if (!bt_r) begin
          state_nxt = ST_WRITE;
        end else begin
          // backtrack step: record the column for this line
          seam_we  = 1'b1;
          seam_wa  = row_r;
          seam_wd  = fin_pick;
          ncol_nxt = fin_pick;
          if (row_r == '0) begin
            phase_done_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            row_nxt   = row_r - 8'd1;
            state_nxt = ST_NB_C;
          end
        end
      end
      ST_WRITE: begin
        cost_we = 1'b1;
        if (!col_last) begin
          col_nxt   = col_r + 8'd1;
          state_nxt = ST_IDLE;
        end else begin
          col_nxt = '0;
          if (!line_last) begin
            line_nxt  = line_r + 8'd1;
            state_nxt = ST_IDLE;
          end else begin
            line_nxt  = '0;
            state_nxt = ST_SCAN0;
          end
        end
      end
      ST_SCAN0: begin
        rd_addr   = {last_line, {COL_W{1'b0}}};
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        best_nxt = sc_best;
        pick_nxt = sc_pick;
        if (k_inc < eff_len) begin
          rd_addr = {last_line, k_inc_col};
          k_nxt   = k_inc;
        end else begin
          seam_we        = 1'b1;
          seam_wa        = last_line;
          seam_wd        = sc_pick;
          best_total_nxt = sc_best;
          row_nxt        = last_line - 8'd1;
          ncol_nxt       = sc_pick;
          bt_nxt         = 1'b1;
          state_nxt      = ST_NB_C;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_LINE_LENGTH: len_nxt = cfg_data;
        REG_LINE_COUNT:  cnt_nxt = cfg_data;
        default: ;
      endcase
      col_nxt        = '0;
      line_nxt       = '0;
      phase_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      col_r        <= '0;
      line_r       <= '0;
      phase_done_r <= 1'b0;
      best_total_r <= '0;
      len_r        <= MAX_LINE_LEN;
      cnt_r        <= MAX_LINE_CNT;
      bt_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
      phase_done_r <= phase_done_nxt;
      best_total_r <= best_total_nxt;
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
      bt_r         <= bt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    row_r      <= row_nxt;
    ncol_r     <= ncol_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    k_r        <= k_nxt;
    energy_r   <= energy_nxt;
    sel_r      <= sel_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    rd_data_r <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (seam_we) seam_mem[seam_wa] <= seam_wd;
    seam_rd_r <= seam_mem[in_data.line_select];
  end

endmodule

`default_nettype wire

@@ rtl/scms_checker.sv @@
// port-level checks for the seam finder, bound to the top level
`default_nettype none

module scms_checker
  import scms_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // a read transfer's result shows up, registered from ST_RESP, with its line number
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_READ
    |-> ##2 out_valid && out_data.line_number == $past(in_data.line_select, 2))
    else $error("read result missing or wrong line");

  // no read is taken while an earlier result is still held
  a_no_read_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_ready |-> in_data.req_type == REQ_LOAD)
    else $error("read taken with result slot full");

  // the block is busy the cycle after a read transfer
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.req_type == REQ_READ |=> !in_ready)
    else $error("ready during read response");

endmodule

bind seam_carving_min_seam_top scms_checker u_scms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the minimum-energy seam finder: image loads with checked seam reads
`default_nettype none

import scms_pkg::*;

class seam_board;
  bit [COST_W-1:0] acc_cost [1 << ADDR_W];
  bit [COL_W-1:0]  seam_col [1 << LINE_W];
  bit              seam_known [1 << LINE_W];
  bit [DIM_W-1:0]  len_reg;
  bit [DIM_W-1:0]  cnt_reg;
  int unsigned     col_at;
  int unsigned     row_at;
  bit [COST_W-1:0] seam_cost;
  bit              image_done;
  out_item_t       pending_reads[$];
  int unsigned     errors;
  int unsigned     reads_checked;
  int unsigned     images_traced;

  function new();
    len_reg       = MAX_LINE_LEN;
    cnt_reg       = MAX_LINE_CNT;
    col_at        = 0;
    row_at        = 0;
    seam_cost     = '0;
    image_done    = 1'b0;
    errors        = 0;
    reads_checked = 0;
    images_traced = 0;
  endfunction

  function int unsigned in_use(bit [DIM_W-1:0] v, bit [DIM_W-1:0] hi);
    if (v < MIN_DIM) return int'(MIN_DIM);
    if (v > hi) return int'(hi);
    return int'(v);
  endfunction

  function int unsigned lines_in_use();
    return in_use(cnt_reg, MAX_LINE_CNT);
  endfunction

  // quiet time the block may need after its last load before it is idle
  function int unsigned settle_cycles();
    return 32 + in_use(len_reg, MAX_LINE_LEN) + 4 * lines_in_use();
  endfunction

  function int unsigned pending();
    return pending_reads.size();
  endfunction

  // a read may touch only seam entries that some finished image wrote
  function bit read_ok(bit [LINE_W-1:0] sel);
    return (sel >= lines_in_use()) || seam_known[sel];
  endfunction

  function void set_reg(logic idx, bit [DIM_W-1:0] v);
    if (idx == REG_LINE_LENGTH) len_reg = v;
    else cnt_reg = v;
    col_at     = 0;
    row_at     = 0;
    image_done = 1'b0;
  endfunction

  function void trace_seam(int unsigned len, int unsigned cnt);
    int unsigned     last;
    int unsigned     best;
    int unsigned     col;
    int unsigned     pick;
    int unsigned     base;
    bit [COST_W-1:0] best_v;
    bit [COST_W-1:0] pick_v;
    last   = cnt - 1;
    base   = last * MAX_LINE_LEN;
    best   = 0;
    best_v = acc_cost[base];
    for (int unsigned c = 1; c < len; c++) begin
      if (acc_cost[base + c] < best_v) begin
        best_v = acc_cost[base + c];
        best   = c;
      end
    end
    seam_col[last]   = COL_W'(best);
    seam_known[last] = 1'b1;
    seam_cost        = best_v;
    for (int unsigned r = last; r > 0; r--) begin
      base   = (r - 1) * MAX_LINE_LEN;
      col    = seam_col[r];
      pick   = col;
      pick_v = acc_cost[base + col];
      if (col > 0 && acc_cost[base + col - 1] < pick_v) begin
        pick   = col - 1;
        pick_v = acc_cost[base + col - 1];
      end
      if (col + 1 < len && acc_cost[base + col + 1] < pick_v) pick = col + 1;
      seam_col[r - 1]   = COL_W'(pick);
      seam_known[r - 1] = 1'b1;
    end
    images_traced++;
  endfunction

  function void note_request(in_item_t it);
    out_item_t       want;
    int unsigned     len;
    int unsigned     cnt;
    int unsigned     base;
    bit [COST_W:0]   sum;
    bit [COST_W-1:0] m;
    len = in_use(len_reg, MAX_LINE_LEN);
    cnt = lines_in_use();
    if (it.req_type == REQ_READ) begin
      want.line_number   = it.line_select;
      want.seam_position = (it.line_select < cnt) ? seam_col[it.line_select] : '0;
      want.seam_total    = seam_cost;
      pending_reads      = {pending_reads, want};
      return;
    end
    // first load after a finished image starts the next one
    if (image_done) begin
      col_at     = 0;
      row_at     = 0;
      image_done = 1'b0;
    end
    sum = (COST_W+1)'(it.pixel_cost);
    if (row_at > 0) begin
      base = (row_at - 1) * MAX_LINE_LEN;
      m    = acc_cost[base + col_at];
      if (col_at > 0 && acc_cost[base + col_at - 1] < m) m = acc_cost[base + col_at - 1];
      if (col_at + 1 < len && acc_cost[base + col_at + 1] < m) m = acc_cost[base + col_at + 1];
      sum = sum + (COST_W+1)'(m);
    end
    acc_cost[row_at * MAX_LINE_LEN + col_at] = sum[COST_W] ? COST_SAT : sum[COST_W-1:0];
    col_at++;
    if (col_at >= len) begin
      col_at = 0;
      row_at++;
      if (row_at >= cnt) begin
        row_at = 0;
        trace_seam(len, cnt);
        image_done = 1'b1;
      end
    end
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_seam_read(out_item_t got);
    out_item_t want;
    if (pending_reads.size() == 0) begin
      flag($sformatf("result with no read outstanding: line %0d pos %0d total %0d",
                     got.line_number, got.seam_position, got.seam_total));
      return;
    end
    want = pending_reads.pop_front();
    reads_checked++;
    if (got.line_number !== want.line_number)
      flag($sformatf("line_number expected %0d got %0d", want.line_number, got.line_number));
    if (got.seam_position !== want.seam_position)
      flag($sformatf("seam_position (line %0d) expected %0d got %0d",
                     want.line_number, want.seam_position, got.seam_position));
    if (got.seam_total !== want.seam_total)
      flag($sformatf("seam_total expected %0d got %0d", want.seam_total, got.seam_total));
  endfunction
endclass

module testbench;
  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RUN_LIMIT   = 5_000_000;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [DIM_W-1:0] cfg_data;

  logic        hold_off = 1'b0;
  bit          keep_offering = 1'b0;
  int unsigned items_sent = 0;
  event        hold_request;
  seam_board   board;

  seam_carving_min_seam_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // idle mix rotates every 50 transfers
  function automatic idle_mode_t idle_mode();
    return idle_mode_t'((items_sent / 50) % 4);
  endfunction

  function automatic int unsigned send_gap_pct();
    if (keep_offering) return 0;
    case (idle_mode())
      IDLE_SEND: return 54;
      IDLE_BOTH: return 28;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned stall_pct();
    case (idle_mode())
      IDLE_RECV: return 54;
      IDLE_BOTH: return 28;
      default:   return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct());
  end

  // long output stall, counted here so the sender keeps offering meanwhile
  initial begin
    forever begin
      @(hold_request);
      @(posedge clk);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) board.check_seam_read(out_data);
  end

  function automatic in_item_t load_item(logic [ENERGY_W-1:0] e);
    in_item_t it;
    it.req_type    = REQ_LOAD;
    it.pixel_cost  = e;
    it.line_select = LINE_W'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t read_item(logic [LINE_W-1:0] sel);
    in_item_t it;
    it.req_type    = REQ_READ;
    it.pixel_cost  = ENERGY_W'($urandom_range(ENERGY_MAX));
    it.line_select = sel;
    return it;
  endfunction

  // small values make ties, the all-ones value stresses the sums
  function automatic logic [ENERGY_W-1:0] pick_energy();
    case ($urandom_range(3))
      0:       return ENERGY_W'($urandom_range(3));
      1:       return ENERGY_W'($urandom_range(255));
      2:       return $urandom_range(1) ? ENERGY_MAX : '0;
      default: return ENERGY_W'($urandom_range(ENERGY_MAX));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_gap_pct()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    board.note_request(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_read();
    logic [LINE_W-1:0] sel;
    if ($urandom_range(1)) sel = LINE_W'($urandom_range(board.lines_in_use() - 1));
    else sel = LINE_W'($urandom_range(255));
    // line 0 is always known once the first image is done
    while (!board.read_ok(sel)) sel = sel - 8'd1;
    send_item(read_item(sel));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (board.settle_cycles()) @(negedge clk);
  endtask

  task automatic write_dims(logic [DIM_W-1:0] len_val, logic [DIM_W-1:0] cnt_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_LENGTH;
    cfg_data  <= len_val;
    @(negedge clk);
    board.set_reg(REG_LINE_LENGTH, len_val);
    cfg_index <= REG_LINE_COUNT;
    cfg_data  <= cnt_val;
    @(negedge clk);
    board.set_reg(REG_LINE_COUNT, cnt_val);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [DIM_W-1:0] len_val, logic [DIM_W-1:0] cnt_val,
                           int unsigned loads, int unsigned read_pct);
    int unsigned done_loads;
    done_loads = 0;
    settle();
    write_dims(len_val, cnt_val);
    while (done_loads < loads) begin
      if ($urandom_range(99) < read_pct) send_random_read();
      else begin
        send_item(load_item(pick_energy()));
        done_loads++;
      end
    end
  endtask

  initial begin
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_LINE_LENGTH;
    cfg_data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // loads at the reset size, abandoned by the first register write
    send_item(load_item(ENERGY_MAX));
    send_item(load_item('0));
    send_item(load_item(ENERGY_W'(12345)));
    settle();
    write_dims(9'd0, 9'd1);

    // 2x2: tie in the last line, right neighbor wins in the backtrack
    send_item(load_item(ENERGY_MAX));
    send_item(load_item('0));
    send_item(load_item(ENERGY_W'(7)));
    send_item(load_item(ENERGY_W'(7)));
    send_item(read_item(8'd0));
    send_item(read_item(8'd1));
    send_item(read_item(8'd2));
    send_item(read_item(8'hFF));
    // reads during a partial image still see the previous seam
    send_item(load_item(ENERGY_W'(3)));
    send_item(load_item(ENERGY_W'(3)));
    send_item(read_item(8'd1));
    send_item(load_item(ENERGY_MAX));
    send_item(load_item(ENERGY_W'(1)));
    send_item(read_item(8'd0));

    // 3x2: left neighbor strictly smaller
    settle();
    write_dims(9'd3, 9'd2);
    send_item(load_item(ENERGY_W'(1)));
    send_item(load_item(ENERGY_W'(1)));
    send_item(load_item(ENERGY_W'(5)));
    send_item(load_item(ENERGY_W'(9)));
    send_item(load_item(ENERGY_W'(9)));
    send_item(load_item('0));
    send_item(read_item(8'd0));
    send_item(read_item(8'd1));

    run_phase(9'd4,   9'd3,   130, 12);
    run_phase(9'd2,   9'd256, 540, 10);
    run_phase(9'd511, 9'd2,   520, 10);
    run_phase(9'd5,   9'd4,   130, 15);
    run_phase(9'd3,   9'd2,   40,  10);

    // output blocked for a long stretch while reads keep coming
    keep_offering = 1'b1;
    -> hold_request;
    repeat (60) send_random_read();
    keep_offering = 1'b0;

    run_phase(9'd6, 9'd6, 100, 15);
    settle();

    $display("%0d transfers in, %0d seam reads checked, %0d images traced",
             items_sent, board.reads_checked, board.images_traced);
    $display("sizes 2x2 to 256 pixels or 256 lines, clamped registers, mixed stalls");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
